// ===== rtl/core/b2da_pkg.sv =====
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants and types for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

  localparam int DEF_MAX_PAD_DIGITS = 16;
  localparam int DEF_VALUE_BITS     = 31;

  localparam int DIGIT_BITS = 4;
  localparam int CH_BITS    = 6;
  localparam int MIN_BITS   = 5;
  localparam int LEN_BITS   = 5;

  localparam logic [CH_BITS-1:0]    ASCII_ZERO = 6'd48;
  localparam logic [CH_BITS-1:0]    ASCII_NUL  = 6'd0;
  localparam logic [DIGIT_BITS-1:0] DIGIT_MAX  = 4'd9;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } b2da_state_t;

  // control broadcast to every digit cell
  typedef struct packed {
    logic clear;
    logic dabble;
    logic move;
  } b2da_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/b2da_cell.sv =====
// ----------------------------------------------------------------------------
// b2da_cell
// One BCD digit of the conversion chain: clear, shift-add-3 step or digit move.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_cell (
  input  wire logic                           clk,
  input  wire b2da_pkg::b2da_ctl_t            ctl,
  input  wire logic                           carry_in,
  input  wire logic [b2da_pkg::DIGIT_BITS-1:0] digit_in,
  output logic      [b2da_pkg::DIGIT_BITS-1:0] digit,
  output logic                                carry_out
);

  logic [b2da_pkg::DIGIT_BITS-1:0] adj;

  // add 3 when the digit would overflow past 9 after doubling
  always_comb begin
    adj       = (digit >= 4'd5) ? digit + 4'd3 : digit;
    carry_out = adj[b2da_pkg::DIGIT_BITS-1];
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= '0;
    end else if (ctl.dabble) begin
      digit <= {adj[b2da_pkg::DIGIT_BITS-2:0], carry_in};
    end else if (ctl.move) begin
      digit <= digit_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b2da_seq.sv =====
// ----------------------------------------------------------------------------
// b2da_seq
// Sequencer: request intake, bit feed into the digit chain, digit emission.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_seq #(
  parameter int MAX_PAD_DIGITS = b2da_pkg::DEF_MAX_PAD_DIGITS,
  parameter int VALUE_BITS     = b2da_pkg::DEF_VALUE_BITS,
  parameter int NUM_DIGITS     = b2da_pkg::DEF_MAX_PAD_DIGITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [VALUE_BITS-1:0]            value,
  input  wire logic [b2da_pkg::MIN_BITS-1:0]    min_digits,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [b2da_pkg::CH_BITS-1:0]     ch,
  output logic                                  last,
  output logic      [b2da_pkg::LEN_BITS-1:0]    length,
  input  wire logic [b2da_pkg::DIGIT_BITS-1:0]  top_digit,
  output b2da_pkg::b2da_ctl_t                   ctl,
  output logic                                  feed_bit
);

  localparam int WW = $clog2(MAX_PAD_DIGITS + 1);
  localparam int PW = $clog2(NUM_DIGITS + 1);
  localparam int BW = $clog2(VALUE_BITS);

  b2da_pkg::b2da_state_t state, state_next;

  logic [VALUE_BITS-1:0] shreg, shreg_next;
  logic [BW-1:0]         bitcnt, bitcnt_next;
  logic [WW-1:0]         want, want_next;
  logic [PW-1:0]         pos, pos_next;
  logic [PW-1:0]         count, count_next;
  logic                  started, started_next;

  logic                              out_free;
  logic                              load_out;
  logic [b2da_pkg::CH_BITS-1:0]      ch_next;
  logic                              last_next;
  logic [b2da_pkg::LEN_BITS-1:0]     length_next;
  logic                              skip;

  assign out_free = !out_valid || !out_stall;
  assign feed_bit = shreg[VALUE_BITS-1];
  assign skip     = !started && (top_digit == '0) && (pos > PW'(want));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= b2da_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    shreg_next   = shreg;
    bitcnt_next  = bitcnt;
    want_next    = want;
    pos_next     = pos;
    count_next   = count;
    started_next = started;
    ctl          = '0;
    in_stall     = 1'b1;
    load_out     = 1'b0;
    ch_next      = b2da_pkg::ASCII_NUL;
    last_next    = 1'b0;
    length_next  = '0;
    case (state)
      b2da_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.clear   = 1'b1;
          shreg_next  = value;
          bitcnt_next = BW'(VALUE_BITS - 1);
          if ({2'b00, min_digits} > 7'(MAX_PAD_DIGITS)) begin
            want_next = WW'(MAX_PAD_DIGITS);
          end else begin
            want_next = WW'(min_digits);
          end
          state_next = b2da_pkg::ST_CONV;
        end
      end
      b2da_pkg::ST_CONV: begin
        // one value bit enters the chain per cycle, msb first
        ctl.dabble = 1'b1;
        shreg_next = {shreg[VALUE_BITS-2:0], 1'b0};
        bitcnt_next = bitcnt - 1'b1;
        if (bitcnt == '0) begin
          pos_next     = PW'(NUM_DIGITS);
          count_next   = '0;
          started_next = 1'b0;
          state_next   = b2da_pkg::ST_EMIT;
        end
      end
      b2da_pkg::ST_EMIT: begin
        if (pos == '0) begin
          if (out_free) begin
            load_out    = 1'b1;
            ch_next     = b2da_pkg::ASCII_NUL;
            last_next   = 1'b1;
            length_next = b2da_pkg::LEN_BITS'(count);
            state_next  = b2da_pkg::ST_IDLE;
          end
        end else if (skip) begin
          // leading zero beyond the minimum width
          ctl.move = 1'b1;
          pos_next = pos - 1'b1;
        end else if (out_free) begin
          load_out     = 1'b1;
          ch_next      = b2da_pkg::ASCII_ZERO + {2'b00, top_digit};
          ctl.move     = 1'b1;
          pos_next     = pos - 1'b1;
          count_next   = count + 1'b1;
          started_next = 1'b1;
        end
      end
      default: begin
        state_next = b2da_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    shreg   <= shreg_next;
    bitcnt  <= bitcnt_next;
    want    <= want_next;
    pos     <= pos_next;
    count   <= count_next;
    started <= started_next;
    if (load_out) begin
      ch     <= ch_next;
      last   <= last_next;
      length <= length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == b2da_pkg::ST_EMIT |->
      ({1'b0, count} + {1'b0, pos}) <= (PW+1)'(NUM_DIGITS))
    else $error("emitted digit count exceeds scanned positions");

  a_top_decimal: assert property (@(posedge clk) disable iff (rst)
    state == b2da_pkg::ST_EMIT |-> top_digit <= b2da_pkg::DIGIT_MAX)
    else $error("non-decimal digit at head of chain");

  a_accept_conv: assert property (@(posedge clk) disable iff (rst)
    (state == b2da_pkg::ST_IDLE && in_valid) |=> state == b2da_pkg::ST_CONV)
    else $error("accepted request did not start conversion");

  a_nul_close: assert property (@(posedge clk) disable iff (rst)
    (state == b2da_pkg::ST_EMIT && pos == '0 && out_free) |=>
      (out_valid && last && state == b2da_pkg::ST_IDLE))
    else $error("closing nul not issued");

  a_digit_ascii: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |->
      (ch >= b2da_pkg::ASCII_ZERO && ch <= b2da_pkg::ASCII_ZERO + 6'(b2da_pkg::DIGIT_MAX)))
    else $error("digit result outside ascii digit range");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Binary integer to zero-padded decimal ASCII text, msd first, nul closed.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_stall, value,       | request in
//          | min_digits                       |
//  out     | out_valid, out_stall, ch, last,  | characters out
//          | length                           |
//
//  one request at a time: intake, VALUE_BITS shift-add-3 steps through the
//  digit chain, then one step per chain position (max of MAX_PAD_DIGITS
//  and the digit count of VALUE_BITS) plus the nul
//  out_stall only holds emission, leading zero positions still advance
//  the next request is taken while the closing nul waits in the output register
//  rst is synchronous and clears the sequencer and output valid
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii #(
  parameter int MAX_PAD_DIGITS = b2da_pkg::DEF_MAX_PAD_DIGITS,
  parameter int VALUE_BITS     = b2da_pkg::DEF_VALUE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [VALUE_BITS-1:0]         value,
  input  wire logic [b2da_pkg::MIN_BITS-1:0] min_digits,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [b2da_pkg::CH_BITS-1:0]  ch,
  output logic                               last,
  output logic      [b2da_pkg::LEN_BITS-1:0] length
);

  // decimal digits of 2^VALUE_BITS - 1
  localparam int VALUE_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int NUM_DIGITS   = (VALUE_DIGITS > MAX_PAD_DIGITS) ?
                                VALUE_DIGITS : MAX_PAD_DIGITS;

  b2da_pkg::b2da_ctl_t ctl;
  logic                feed_bit;

  logic [b2da_pkg::DIGIT_BITS-1:0] dig [NUM_DIGITS];
  logic [NUM_DIGITS-1:0]           carry;

  b2da_seq #(
    .MAX_PAD_DIGITS (MAX_PAD_DIGITS),
    .VALUE_BITS     (VALUE_BITS),
    .NUM_DIGITS     (NUM_DIGITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .min_digits (min_digits),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ch         (ch),
    .last       (last),
    .length     (length),
    .top_digit  (dig[NUM_DIGITS-1]),
    .ctl        (ctl),
    .feed_bit   (feed_bit)
  );

  // cell 0 holds the least significant digit; digits move upward on emission
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      b2da_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .carry_in  (feed_bit),
        .digit_in  ('0),
        .digit     (dig[i]),
        .carry_out (carry[i])
      );
    end else begin : g_rest
      b2da_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .carry_in  (carry[i-1]),
        .digit_in  (dig[i-1]),
        .digit     (dig[i]),
        .carry_out (carry[i])
      );
    end
  end

endmodule

`default_nettype wire
